// File: design/smf_pkg.sv
// Shared constants and types of the sliding median filter.
// No dependencies; every other design file imports this package.

package smf_pkg;

   localparam int MAX_WINDOW_DEF  = 31;
   localparam int SAMPLE_BITS_DEF = 32;

   localparam int WINDOW_BITS   = 5;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CSR_ADDR_BITS-1:0] REG_WINDOW_SIZE_ADDR = 2'd0;
   localparam logic [WINDOW_BITS-1:0]   WINDOW_SIZE_RESET    = 5'd1;

   // Operation broadcast to every cell of the sorted chain
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DROP
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        clear;
   } chain_ctrl_type;

endpackage

// File: design/smf_cell.sv
// One slot of the sorted sample chain: a value and its age.
// Depends on smf_pkg for the cell operation codes.

module smf_cell #(
   parameter int SAMPLE_BITS = 32,
   parameter int AGE_W       = 5
) (
   input  logic                          clock,
   input  smf_pkg::cell_op_type          op,
   input  logic signed [SAMPLE_BITS-1:0] new_sample,
   input  logic                          cell_valid,
   input  logic [AGE_W-1:0]              oldest_age,
   input  logic signed [SAMPLE_BITS-1:0] left_value,
   input  logic [AGE_W-1:0]              left_age,
   input  logic                          left_lt,
   input  logic                          left_rm,
   input  logic signed [SAMPLE_BITS-1:0] right_value,
   input  logic [AGE_W-1:0]              right_age,
   output logic signed [SAMPLE_BITS-1:0] value,
   output logic [AGE_W-1:0]              age,
   output logic                          lt,
   output logic                          rm
);
   import smf_pkg::*;

   logic signed [SAMPLE_BITS-1:0] value_ff;
   logic signed [SAMPLE_BITS-1:0] value_in;
   logic [AGE_W-1:0]              age_ff;
   logic [AGE_W-1:0]              age_in;

   // New sample sorts before this entry; true on a suffix of the valid cells
   assign lt    = cell_valid && (new_sample < value_ff);
   // Oldest entry is here or to the left: close the gap by pulling from the right
   assign rm    = left_rm || (cell_valid && (age_ff == oldest_age));
   assign value = value_ff;
   assign age   = age_ff;

   always_comb begin
      value_in = value_ff;
      age_in   = age_ff;
      unique case (op)
         CELL_INSERT: begin
            if (left_lt) begin
               value_in = left_value;
               age_in   = left_age + 1'b1;
            end else if (lt || !cell_valid) begin
               value_in = new_sample;
               age_in   = '0;
            end else begin
               age_in = age_ff + 1'b1;
            end
         end
         CELL_DROP: begin
            if (rm) begin
               value_in = right_value;
               age_in   = right_age;
            end
         end
         default: begin
            value_in = value_ff;
            age_in   = age_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      age_ff   <= age_in;
   end

endmodule

// File: design/smf_chain.sv
// Row of smf_cell slots kept in ascending signed order, plus the median tap.
// Depends on smf_pkg and smf_cell.

module smf_chain #(
   parameter int MAX_WINDOW  = 31,
   parameter int SAMPLE_BITS = 32,
   parameter int CNT_W       = $clog2(MAX_WINDOW + 1)
) (
   input  logic                          clock,
   input  smf_pkg::chain_ctrl_type       ctrl,
   input  logic signed [SAMPLE_BITS-1:0] new_sample,
   input  logic [CNT_W-1:0]              count,
   output logic signed [SAMPLE_BITS-1:0] median
);
   import smf_pkg::*;

   localparam int IDX_W = $clog2(MAX_WINDOW);

   logic signed [SAMPLE_BITS-1:0] value_w [MAX_WINDOW];
   logic [IDX_W-1:0]              age_w   [MAX_WINDOW];
   logic [MAX_WINDOW-1:0]         lt_w;
   logic [MAX_WINDOW-1:0]         rm_w;
   logic [MAX_WINDOW-1:0]         valid_w;
   logic [IDX_W-1:0]              oldest_age;
   cell_op_type                   cell_op;

   // Ages run 0 .. count-1, so the oldest entry carries count-1
   assign oldest_age = IDX_W'(count - 1'b1);
   assign cell_op    = ctrl.clear ? CELL_HOLD : ctrl.op;

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      logic signed [SAMPLE_BITS-1:0] left_value;
      logic [IDX_W-1:0]              left_age;
      logic                          left_lt;
      logic                          left_rm;
      logic signed [SAMPLE_BITS-1:0] right_value;
      logic [IDX_W-1:0]              right_age;

      assign valid_w[i] = count > CNT_W'(i);

      if (i == 0) begin : g_head
         assign left_value = new_sample;
         assign left_age   = '0;
         assign left_lt    = 1'b0;
         assign left_rm    = 1'b0;
      end else begin : g_body
         assign left_value = value_w[i-1];
         assign left_age   = age_w[i-1];
         assign left_lt    = lt_w[i-1];
         assign left_rm    = rm_w[i-1];
      end

      if (i == MAX_WINDOW - 1) begin : g_tail
         assign right_value = value_w[i];
         assign right_age   = age_w[i];
      end else begin : g_inner
         assign right_value = value_w[i+1];
         assign right_age   = age_w[i+1];
      end

      smf_cell #(
         .SAMPLE_BITS(SAMPLE_BITS),
         .AGE_W      (IDX_W)
      ) u_cell (
         .clock      (clock),
         .op         (cell_op),
         .new_sample (new_sample),
         .cell_valid (valid_w[i]),
         .oldest_age (oldest_age),
         .left_value (left_value),
         .left_age   (left_age),
         .left_lt    (left_lt),
         .left_rm    (left_rm),
         .right_value(right_value),
         .right_age  (right_age),
         .value      (value_w[i]),
         .age        (age_w[i]),
         .lt         (lt_w[i]),
         .rm         (rm_w[i])
      );
   end

   // Upper median: element count/2 of the sorted entries
   assign median = value_w[IDX_W'(count >> 1)];

endmodule

// File: design/sliding_median_filter.sv
// Top level of the sliding median filter: sequencer, CSR port, result register.
// Depends on smf_pkg and smf_chain.

// Samples of one array enter on req_ with req_last_in on the final one; each
// result on rsp_ is the upper median of the window around one array position,
// clipped at both array ends, with rsp_last_out on the final result. The window
// register at byte address 0 gives half = window_size/2 (capped at
// (MAX_WINDOW-1)/2); a window of 0 or 1 passes samples through. Samples sit in
// a chain of sorted cells that does one operation per cycle unless rsp_stall
// holds an emit (drop oldest, insert, or emit). Each sample drops the entries
// that leave its window, is inserted, then emits the results now due; req_stall
// holds off the next sample until then. Results lag the input by half
// positions and the last sample flushes every pending result.
module sliding_median_filter #(
   parameter int MAX_WINDOW  = smf_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [SAMPLE_BITS-1:0]      req_sample,
   input  logic                               req_last_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]      rsp_median,
   output logic                               rsp_last_out,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [smf_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [smf_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [smf_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import smf_pkg::*;

   localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
   localparam int CMP_W    = CNT_W + 1;
   localparam int HALF_CAP = (MAX_WINDOW - 1) / 2;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PRE  = 2'd1;
   localparam logic [1:0] S_POST = 2'd2;

   logic [1:0]                    state_ff;
   logic [1:0]                    state_in;
   logic [WINDOW_BITS-1:0]        window_ff;
   logic [WINDOW_BITS-1:0]        window_in;
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              count_in;
   logic [CNT_W-1:0]              lead_ff;
   logic [CNT_W-1:0]              lead_in;
   logic [CNT_W-1:0]              half_ff;
   logic [CNT_W-1:0]              half_in;
   logic                          last_ff;
   logic                          last_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_median_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_median_in;
   logic                          rsp_last_ff;
   logic                          rsp_last_in;

   logic                          req_accept;
   logic                          csr_write;
   logic [WINDOW_BITS-1:0]        half_raw;
   logic [WINDOW_BITS-1:0]        half_sel;
   logic [CMP_W-1:0]              count_x;
   logic [CMP_W-1:0]              pre_limit;
   logic [CMP_W-1:0]              post_limit;
   logic                          pending;
   logic                          drop_pre;
   logic                          drop_post;
   logic                          slot_free;
   logic                          emit_fire;
   logic                          array_done;
   chain_ctrl_type                ctrl;
   logic signed [SAMPLE_BITS-1:0] chain_median;

   // CSR port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == REG_WINDOW_SIZE_ADDR);
   assign window_in  = csr_write ? csr_pwdata[WINDOW_BITS-1:0] : window_ff;

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == REG_WINDOW_SIZE_ADDR) begin
         csr_prdata = CSR_DATA_BITS'(window_ff);
      end
   end

   assign half_raw = window_ff >> 1;
   assign half_sel = (half_raw > WINDOW_BITS'(HALF_CAP)) ? WINDOW_BITS'(HALF_CAP) : half_raw;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign count_x    = {1'b0, count_ff};
   assign pre_limit  = {half_ff, 1'b0};
   assign post_limit = {1'b0, lead_ff} + {1'b0, half_ff};
   assign pending    = (lead_ff > half_ff) || (last_ff && (lead_ff != '0));
   assign drop_pre   = count_x > pre_limit;
   assign drop_post  = count_x > post_limit;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_fire  = (state_ff == S_POST) && pending && !drop_post && slot_free;
   assign array_done = (state_ff == S_POST) && !pending && last_ff;

   always_comb begin
      ctrl.op    = CELL_HOLD;
      ctrl.clear = array_done;
      unique case (state_ff)
         S_PRE:   ctrl.op = drop_pre ? CELL_DROP : CELL_INSERT;
         S_POST:  ctrl.op = (pending && drop_post) ? CELL_DROP : CELL_HOLD;
         default: ctrl.op = CELL_HOLD;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      lead_in   = lead_ff;
      half_in   = half_ff;
      last_in   = last_ff;
      sample_in = sample_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               sample_in = req_sample;
               last_in   = req_last_in;
               half_in   = CNT_W'(half_sel);
               state_in  = S_PRE;
            end
         end
         S_PRE: begin
            if (drop_pre) begin
               count_in = count_ff - 1'b1;
            end else begin
               count_in = count_ff + 1'b1;
               lead_in  = lead_ff + 1'b1;
               state_in = S_POST;
            end
         end
         S_POST: begin
            if (pending) begin
               if (drop_post) begin
                  count_in = count_ff - 1'b1;
               end else if (emit_fire) begin
                  lead_in = lead_ff - 1'b1;
               end
            end else begin
               // End of array: start the next one empty
               if (last_ff) begin
                  count_in = '0;
                  lead_in  = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Result register: load on emit, drop once the transfer completes
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_median_in = rsp_median_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_median_in = chain_median;
         rsp_last_in   = last_ff && (lead_ff == CNT_W'(1));
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         window_ff    <= WINDOW_SIZE_RESET;
         count_ff     <= '0;
         lead_ff      <= '0;
         half_ff      <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         count_ff     <= count_in;
         lead_ff      <= lead_in;
         half_ff      <= half_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      rsp_median_ff <= rsp_median_in;
      rsp_last_ff   <= rsp_last_in;
   end

   smf_chain #(
      .MAX_WINDOW (MAX_WINDOW),
      .SAMPLE_BITS(SAMPLE_BITS),
      .CNT_W      (CNT_W)
   ) u_chain (
      .clock     (clock),
      .ctrl      (ctrl),
      .new_sample(sample_ff),
      .count     (count_ff),
      .median    (chain_median)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_median   = rsp_median_ff;
   assign rsp_last_out = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_WINDOW))
      else $error("sorted chain holds more entries than it has cells");

   a_emit_pending: assert property (@(posedge clock) disable iff (reset)
      emit_fire |-> (lead_ff != '0) && (count_ff != '0))
      else $error("result emitted with no pending position or empty chain");

   a_array_clear: assert property (@(posedge clock) disable iff (reset)
      array_done |=> (count_ff == '0) && (lead_ff == '0) && (state_ff == S_IDLE))
      else $error("chain not cleared after the final result of an array");

endmodule
